FILE: src/itw_pkg.sv
// itw_pkg: token codes, widths and the binary-to-decimal step shared by the
// integer_to_word_tokens modules. No dependencies.
`timescale 1ns / 1ps

package itw_pkg;

  localparam int unsigned ValueW      = 31;
  localparam int unsigned CodeW       = 5;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned BcdW        = 4 * NumDigits;
  localparam int unsigned BinW        = 32;
  localparam int unsigned BitsPerCyc  = 2;
  localparam int unsigned ConvCycles  = BinW / BitsPerCyc;
  localparam int unsigned CntW        = $clog2(ConvCycles);
  localparam int unsigned NumGroups   = 4;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned NumSlots    = NumGroups * NumPhases;

  localparam logic [CodeW-1:0] TokZero     = 5'd0;
  localparam logic [CodeW-1:0] TokTeen0    = 5'd10;
  localparam logic [CodeW-1:0] TokTens0    = 5'd18;
  localparam logic [CodeW-1:0] TokHundred  = 5'd28;
  localparam logic [CodeW-1:0] TokThousand = 5'd29;
  localparam logic [CodeW-1:0] TokMillion  = 5'd30;
  localparam logic [CodeW-1:0] TokBillion  = 5'd31;

  // slot phases within one group of three digits
  localparam logic [2:0] PhHundDigit = 3'd0;
  localparam logic [2:0] PhHundred   = 3'd1;
  localparam logic [2:0] PhTens      = 3'd2;
  localparam logic [2:0] PhUnits     = 3'd3;
  localparam logic [2:0] PhScale     = 3'd4;

  typedef logic [BcdW-1:0] bcd_t;

  typedef struct packed {
    logic [CodeW-1:0] word_code;
    logic             last_word;
  } token_t;

  // one shift-and-add-3 step: add 3 to every digit of 5 or more, then shift in one binary bit
  function automatic bcd_t dabble_step(bcd_t bcd, logic bin_bit);
    bcd_t adj;
    adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], bin_bit};
  endfunction

endpackage

FILE: src/itw_value_if.sv
// itw_value_if: input channel of integer_to_word_tokens, valid/ready and value.
// No dependencies.
`timescale 1ns / 1ps

interface itw_value_if;
  logic        valid;
  logic        ready;
  logic [30:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: src/itw_word_if.sv
// itw_word_if: output channel of integer_to_word_tokens, one word token per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface itw_word_if;
  logic       valid;
  logic       ready;
  logic [4:0] word_code;
  logic       last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink (input valid, input word_code, input last_word, output ready);
endinterface

FILE: src/integer_to_word_tokens.sv
// integer_to_word_tokens: reads a non-negative 31-bit integer out as English word tokens.
// Depends on itw_pkg, itw_value_if, itw_word_if, itw_front, itw_fifo, itw_back.
//
// Usage:
//   value_i is a valid/ready sink carrying one 31-bit value per transfer.
//   word_o is a valid/ready source carrying one word token per transfer,
//   word_code as listed in the token table and last_word high on the final
//   token of each value. A value gives 1 to 16 tokens.
// The converter works on one value at a time, two binary bits per cycle
//   through a shift-and-add-3 register, and takes the next value while it pushes
//   the last one into the queue; the sequencer gives one token per cycle while
//   the receiver takes them.
// A queue of QueueDepth decimal values sits between converter and sequencer,
//   so conversion goes on while the receiver stalls; word_o holds its token
//   until taken. value_i.ready is low while the converter works on a value
//   and while it holds a finished value that the full queue cannot take.
// Reset: rst_ni is asynchronous and active low; it empties the converter,
//   the queue and the output register. No state survives between values.
`timescale 1ns / 1ps

module integer_to_word_tokens #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itw_value_if.sink   value_i,
  itw_word_if.source  word_o
);
  import itw_pkg::*;

  logic   front_push, fifo_full, fifo_valid, fifo_pop;
  bcd_t   front_bcd, fifo_data;
  token_t token;

  itw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (value_i.valid),
    .value_i    (value_i.value),
    .in_ready_o (value_i.ready),
    .full_i     (fifo_full),
    .push_o     (front_push),
    .bcd_o      (front_bcd)
  );

  itw_fifo #(
    .Width ($bits(bcd_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_bcd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  itw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .pop_o        (fifo_pop),
    .out_valid_o  (word_o.valid),
    .out_ready_i  (word_o.ready),
    .token_o      (token)
  );

  assign word_o.word_code = token.word_code;
  assign word_o.last_word = token.last_word;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !fifo_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> fifo_valid)
    else $error("queue read while empty");

  a_zero_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_o.valid && (word_o.word_code == TokZero)) |-> word_o.last_word)
    else $error("zero token without last marker");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_o.valid && !word_o.ready) |=> (word_o.valid && $stable(token)))
    else $error("word token changed while stalled");

endmodule

FILE: src/itw_front.sv
// itw_front: accepts a value and converts it to ten decimal digits, two bits per cycle.
// Depends on itw_pkg.
`timescale 1ns / 1ps

module itw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [itw_pkg::ValueW-1:0]    value_i,
  output logic                          in_ready_o,
  input  logic                          full_i,
  output logic                          push_o,
  output itw_pkg::bcd_t                 bcd_o
);
  import itw_pkg::*;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BinW-1:0] bin_q;
  bcd_t            bcd_q;
  bcd_t            step1, step2;
  logic            last_iter, adv, accept;

  assign step1     = dabble_step(bcd_q, bin_q[BinW-1]);
  assign step2     = dabble_step(step1, bin_q[BinW-2]);
  assign last_iter = busy_q && (cnt_q == CntW'(ConvCycles - 1));
  assign push_o    = last_iter && !full_i;
  assign adv       = busy_q && (!last_iter || !full_i);
  assign in_ready_o = !busy_q || push_o;
  assign accept    = in_valid_i && in_ready_o;
  assign bcd_o     = step2;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (adv) begin
      if (last_iter) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q <= {1'b0, value_i};
      bcd_q <= '0;
    end else if (adv && !last_iter) begin
      bin_q <= {bin_q[BinW-BitsPerCyc-1:0], {BitsPerCyc{1'b0}}};
      bcd_q <= step2;
    end
  end

endmodule

FILE: src/itw_fifo.sv
// itw_fifo: short register queue between the converter and the token sequencer.
// No dependencies.
`timescale 1ns / 1ps

module itw_fifo #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/itw_back.sv
// itw_back: walks the word slots of one decimal value and drives the output register.
// Depends on itw_pkg.
`timescale 1ns / 1ps

module itw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  itw_pkg::bcd_t     fifo_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output itw_pkg::token_t   token_o
);
  import itw_pkg::*;

  logic [NumSlots-1:0] mask_q, mask_d;
  bcd_t                dig_q;
  logic                out_valid_q;
  token_t              token_q;
  logic [NumSlots-1:0] low;
  logic                have, emit, single;
  logic [CodeW-1:0]    code;

  // group 0 is billions and holds only one digit; group 3 is units
  function automatic logic [11:0] group_digits(bcd_t d, int g);
    logic [11:0] r;
    if (g == 0) begin
      r = {8'd0, d[4*9 +: 4]};
    end else begin
      r = d[12*(3-g) +: 12];
    end
    return r;
  endfunction

  function automatic logic [NumSlots-1:0] build_mask(bcd_t d);
    logic [NumSlots-1:0] m;
    logic [11:0]         gd;
    logic [3:0]          h, t, u;
    m = '0;
    for (int g = 0; g < NumGroups; g++) begin
      gd = group_digits(d, g);
      h = gd[11:8];
      t = gd[7:4];
      u = gd[3:0];
      m[g*NumPhases + 0] = (h != 4'd0);
      m[g*NumPhases + 1] = (h != 4'd0);
      m[g*NumPhases + 2] = (t >= 4'd2);
      m[g*NumPhases + 3] = (t == 4'd1) || (u != 4'd0);
      m[g*NumPhases + 4] = (g < NumGroups - 1) && (gd != 12'd0);
    end
    // zero value: unit group scale slot carries the word zero
    if (d == '0) begin
      m[NumSlots-1] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [CodeW-1:0] slot_code(bcd_t d, int g, logic [2:0] ph);
    logic [11:0]      gd;
    logic [CodeW-1:0] c;
    gd = group_digits(d, g);
    case (ph)
      PhHundDigit: c = {1'b0, gd[11:8]};
      PhHundred:   c = TokHundred;
      PhTens:      c = TokTens0 + {1'b0, gd[7:4]};
      PhUnits:     c = (gd[7:4] == 4'd1) ? TokTeen0 + {1'b0, gd[3:0]} : {1'b0, gd[3:0]};
      PhScale: begin
        case (g)
          0:       c = TokBillion;
          1:       c = TokMillion;
          2:       c = TokThousand;
          default: c = TokZero;
        endcase
      end
      default:     c = TokZero;
    endcase
    return c;
  endfunction

  assign have   = (mask_q != '0);
  assign low    = mask_q & (~mask_q + 1'b1);
  assign single = ((mask_q & ~low) == '0);
  assign emit   = have && (!out_valid_q || out_ready_i);
  assign pop_o  = fifo_valid_i && (!have || (emit && single));

  always_comb begin
    code = '0;
    for (int g = 0; g < NumGroups; g++) begin
      for (int p = 0; p < NumPhases; p++) begin
        if (low[g*NumPhases + p]) begin
          code = code | slot_code(dig_q, g, 3'(p));
        end
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d = build_mask(fifo_data_i);
    end else if (emit) begin
      mask_d = mask_q & ~low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dig_q <= fifo_data_i;
    end
    if (emit) begin
      token_q.word_code <= code;
      token_q.last_word <= single;
    end
  end

  assign out_valid_o = out_valid_q;
  assign token_o     = token_q;

endmodule

FILE: tb/sv/integer_to_word_tokens_tb.sv
// integer_to_word_tokens_tb: self-checking bench for integer_to_word_tokens, directed
// table then random values, with random idle on both channels.
// Depends on itw_pkg, itw_value_if, itw_word_if and integer_to_word_tokens.
`timescale 1ns / 1ps

module integer_to_word_tokens_tb;
  import itw_pkg::*;

  localparam int unsigned NumRandom = 290;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 24;
  localparam logic [30:0] ValueMax = 31'h7fff_ffff;

  localparam logic [CodeW-1:0] WordOne = TokZero + 5'd1;
  localparam logic [CodeW-1:0] WordNineteen = TokTeen0 + 5'd9;
  localparam logic [CodeW-1:0] WordTwenty = TokTens0 + 5'd2;

  localparam int unsigned ScaleDiv [3] = '{1000000000, 1000000, 1000};
  localparam logic [CodeW-1:0] ScaleWord [3] = '{TokBillion, TokMillion, TokThousand};

  // n_words of zero means the row is checked against the predictor
  typedef struct packed {
    logic [30:0]            value;
    logic [2:0]             n_words;
    logic [0:3][CodeW-1:0]  words;
  } value_row_t;

  localparam int unsigned NumDirected = 24;
  localparam value_row_t DirRows [NumDirected] = '{
    '{31'd0,          3'd1, {TokZero, 15'd0}},
    '{31'd1,          3'd1, {WordOne, 15'd0}},
    '{31'd19,         3'd1, {WordNineteen, 15'd0}},
    '{31'd20,         3'd1, {WordTwenty, 15'd0}},
    '{31'd100,        3'd2, {WordOne, TokHundred, 10'd0}},
    '{31'd1000,       3'd2, {WordOne, TokThousand, 10'd0}},
    '{31'd1000000,    3'd2, {WordOne, TokMillion, 10'd0}},
    '{31'd1000000000, 3'd2, {WordOne, TokBillion, 10'd0}},
    '{ValueMax,       3'd0, 20'd0},
    '{31'd1777777777, 3'd0, 20'd0},
    '{31'd9,          3'd0, 20'd0},
    '{31'd10,         3'd0, 20'd0},
    '{31'd11,         3'd0, 20'd0},
    '{31'd21,         3'd0, 20'd0},
    '{31'd99,         3'd0, 20'd0},
    '{31'd101,        3'd0, 20'd0},
    '{31'd110,        3'd0, 20'd0},
    '{31'd999,        3'd0, 20'd0},
    '{31'd1001,       3'd0, 20'd0},
    '{31'd1000010,    3'd0, 20'd0},
    '{31'd2000000000, 3'd0, 20'd0},
    '{31'd2000000019, 3'd0, 20'd0},
    '{31'd30000000,   3'd0, 20'd0},
    '{31'd12345,      3'd0, 20'd0}
  };

  logic clk_i;
  logic rst_ni;

  itw_value_if value_ch ();
  itw_word_if  word_ch ();

  integer_to_word_tokens i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .value_i(value_ch),
    .word_o (word_ch)
  );

  token_t      expected_words [$];
  int unsigned mismatches;
  int unsigned values_sent;
  int unsigned words_checked;
  int unsigned longest_reading;
  int unsigned idle_cycles;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  function automatic void push_word(logic [CodeW-1:0] code);
    token_t tok;
    tok.word_code = code;
    tok.last_word = 1'b0;
    expected_words.insert(expected_words.size(), tok);
  endfunction

  // one group of three digits, 1..999
  function automatic void push_group(int unsigned grp);
    int unsigned rest;
    rest = grp;
    if (rest >= 100) begin
      push_word(CodeW'(rest / 100));
      push_word(TokHundred);
      rest %= 100;
    end
    if (rest >= 20) begin
      push_word(TokTens0 + CodeW'(rest / 10));
      rest %= 10;
    end
    if (rest != 0) begin
      push_word(CodeW'(rest));
    end
  endfunction

  function automatic void predict_words(logic [30:0] v);
    int unsigned rest;
    int unsigned grp;
    if (v == 0) begin
      push_word(TokZero);
    end else begin
      rest = v;
      for (int i = 0; i < 3; i++) begin
        grp = rest / ScaleDiv[i];
        rest %= ScaleDiv[i];
        if (grp != 0) begin
          push_group(grp);
          push_word(ScaleWord[i]);
        end
      end
      if (rest != 0) begin
        push_group(rest);
      end
    end
  endfunction

  // drive one value, block until its transfer, then queue its expected words
  task automatic send_value(input value_row_t row);
    int unsigned gap;
    int unsigned first;
    gap = pick_gap();
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= row.value;
    do @(posedge clk_i); while (!value_ch.ready);
    first = expected_words.size();
    if (row.n_words == 0) begin
      predict_words(row.value);
    end else begin
      for (int k = 0; k < row.n_words; k++) begin
        push_word(row.words[k]);
      end
    end
    expected_words[expected_words.size() - 1].last_word = 1'b1;
    if (expected_words.size() - first > longest_reading) begin
      longest_reading = expected_words.size() - first;
    end
    values_sent++;
  endtask

  function automatic int unsigned pick_group();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return 0;
    end else if (r == 3) begin
      return $urandom_range(1, 19);
    end else if (r == 4) begin
      return $urandom_range(1, 9) * 100 + $urandom_range(0, 20);
    end
    return $urandom_range(0, 999);
  endfunction

  function automatic logic [30:0] pick_value();
    longint unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom & ValueMax;
      1: v = $urandom_range(0, 999);
      5: v = ValueMax - $urandom_range(0, 1000);
      default: begin
        v = longint'($urandom_range(0, 2)) * 1000000000 + pick_group() * 1000000
          + pick_group() * 1000 + pick_group();
        if (v > ValueMax) begin
          v -= 1000000000;
        end
      end
    endcase
    return v[30:0];
  endfunction

  // stimulus
  initial begin
    value_row_t row;
    rst_ni <= 1'b0;
    value_ch.valid <= 1'b0;
    value_ch.value <= '0;
    mismatches = 0;
    values_sent = 0;
    words_checked = 0;
    longest_reading = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_value(DirRows[i]);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        no_idle = ~no_idle;
      end
      row = '{value: pick_value(), n_words: 3'd0, words: '0};
      send_value(row);
    end
    value_ch.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("values read out: %0d (%0d from the table), word tokens checked: %0d",
             values_sent, NumDirected, words_checked);
    $display("longest reading: %0d tokens", longest_reading);
    if (mismatches == 0) begin
      $display("[integer_to_word_tokens] OK");
    end else begin
      $display("[integer_to_word_tokens] ERROR");
    end
    $finish;
  end

  // receiver with random stalls
  initial begin
    int unsigned stall;
    word_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        word_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      word_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // word checker
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && word_ch.valid && word_ch.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected word transfer: word_code %0d last_word %0b",
               word_ch.word_code, word_ch.last_word);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (word_ch.word_code !== want.word_code) begin
          $error("word_code: expected %0d, got %0d", want.word_code, word_ch.word_code);
          mismatches++;
        end
        if (word_ch.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word, word_ch.last_word);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (value_ch.valid && value_ch.ready) || (word_ch.valid && word_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a transfer", IdleLimit);
      $display("[integer_to_word_tokens] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
